[sv/sync_fifo_bypass_regpop_top_defines.svh]
// Assertion macros for the FIFO RTL, included by the top level.
`ifndef SYNC_FIFO_BYPASS_REGPOP_TOP_DEFINES_SVH
`define SYNC_FIFO_BYPASS_REGPOP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define SFBR_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define SFBR_NEVER(label, clk, rstn, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define SFBR_ASSERT(label, clk, rstn, prop, msg)
`define SFBR_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

[sv/sfbr_pkg.sv]
// Package: defaults and register indexes for the bypass/regpop FIFO.
`default_nettype none

package sfbr_pkg;

	localparam int DEPTH_DEF      = 8;
	localparam int DATA_WIDTH_DEF = 32;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_BYPASS   = 2'd0,
		CFG_REG_PUSH = 2'd1,
		CFG_REG_POP  = 2'd2
	} cfg_idx_t;

	// write request into the slot store
	typedef struct packed {
		logic we;
		logic fwd;
	} store_ctl_t;

endpackage

`default_nettype wire

[sv/sfbr_store.sv]
// Slot store: memory with registered head read, write forwarding and written-slot tracking.
`default_nettype none

module sfbr_store
	import sfbr_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int SLOTS = DEPTH + 1,
	localparam int PW    = $clog2(DEPTH + 2),
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire store_ctl_t            ctl,      // we: store wdata; fwd: wdata lands at raddr_n
	input  wire logic [PW-1:0]         waddr,
	input  wire logic [DATA_WIDTH-1:0] wdata,
	input  wire logic [PW-1:0]         raddr_n,  // read pointer after this edge
	output logic [DATA_WIDTH-1:0]      head
);

	logic [DATA_WIDTH-1:0] mem [SLOTS];
	logic [DATA_WIDTH-1:0] rd_q;
	logic [DATA_WIDTH-1:0] fwd_data_q;
	logic                  fwd_q;
	logic                  zero_q;
	logic                  wrapped_q;
	logic                  written_n;

	// writes go strictly in order from slot 0, so an entry holds data once
	// the write pointer has passed it or has wrapped at least once
	assign written_n = wrapped_q || (raddr_n < waddr);

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		rd_q       <= mem[raddr_n[AW-1:0]];
		fwd_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrapped_q <= 1'b0;
			fwd_q     <= 1'b0;
			zero_q    <= 1'b1;
		end else begin
			if (ctl.we && waddr == PW'(SLOTS - 1)) begin
				wrapped_q <= 1'b1;
			end
			fwd_q  <= ctl.fwd;
			zero_q <= !written_n;
		end
	end

	always_comb begin
		if (fwd_q) begin
			head = fwd_data_q;
		end else if (zero_q) begin
			head = '0;
		end else begin
			head = rd_q;
		end
	end

endmodule

`default_nettype wire

[sv/sync_fifo_bypass_regpop_top.sv]
// Top level: cycle-item FIFO with bypass, registered push and registered pop modes.
// Usage:
//   Each request on the s_ channel is one FIFO clock cycle: push offer flag, push word
//   and pop_ready as the neighbors would drive them. For each accepted request
//   the m_ channel returns one response: push-accept flag, pop-valid flag and pop_data
//   seen in that cycle, after which the FIFO state (pointers, occupancy, slots, output
//   stage) advances.
//   Responses are registered: a response appears in the cycle after its request is accepted.
//   Throughput: one request per cycle while no response is stalled; the output
//   register accepts a new response in the same cycle the old one is taken.
//   Slot memory is read through a registered head word with write forwarding;
//   never-written slots read as zero, tracked by a wrap flag instead of per-slot
//   valid bits, so no clearing pass runs after reset.
//   Config: cfg_valid/cfg_index/cfg_data writes one mode bit (bit 0 only);
//   index 0 bypass, 1 registered push, 2 registered pop; other indexes ignored.
//   cfg_ready is always high. Write modes only while idle.
//   Reset (arst_n low): modes, pointers, occupancy, output stage cleared.
//   Stall: while m_tready is low and a response waits, s_tready drops and
//   FIFO state holds.
`default_nettype none
`include "sync_fifo_bypass_regpop_top_defines.svh"

module sync_fifo_bypass_regpop_top
	import sfbr_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int TW = ((DATA_WIDTH + 2 + 7) / 8) * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request channel
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [TW-1:0] s_tdata,   // push offer, push word, pop_ready, zero pad
	// response channel
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [TW-1:0]      m_tdata,   // push accept, pop valid, pop_data, zero pad
	// mode register writes
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic          cfg_data
);

	localparam int SLOTS = DEPTH + 1;
	localparam int PW    = $clog2(DEPTH + 2);

	// mode registers
	logic byp_en_q, reg_push_q, reg_pop_q;

	// FIFO state
	logic [PW-1:0]         wp_q, rp_q, occ_q;
	logic                  ovr_q;      // output stage valid
	logic [DATA_WIDTH-1:0] odr_q;      // output stage data

	// response register
	logic          m_valid_q;
	logic [TW-1:0] m_data_q;

	// request fields
	logic                  pv, pr;
	logic [DATA_WIDTH-1:0] pd;

	// cycle logic
	logic                  acc;
	logic                  not_full, empty;
	logic                  load_en, bpr, bpr2, can_push, byp, skip;
	logic                  accept_ok, pvi, did_push, did_pop;
	logic                  out_avail, pushed, popped;
	logic [DATA_WIDTH-1:0] head, pop_data_int, pop_data_out;
	logic [PW-1:0]         wp_n, rp_n, occ_n;
	store_ctl_t            sctl;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pv = s_tdata[0];
	assign pd = s_tdata[DATA_WIDTH:1];
	assign pr = s_tdata[DATA_WIDTH+1];

	assign s_tready  = !m_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_en_q   <= 1'b0;
			reg_push_q <= 1'b0;
			reg_pop_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BYPASS:   byp_en_q   <= cfg_data;
				CFG_REG_PUSH: reg_push_q <= cfg_data;
				CFG_REG_POP:  reg_pop_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake decisions of one FIFO cycle
	always_comb begin
		not_full = occ_q != PW'(DEPTH);
		empty    = wp_q == rp_q;
		load_en  = reg_pop_q && (pr || !ovr_q);
		bpr      = reg_pop_q ? load_en : pr;
		can_push = not_full || bpr;
		byp      = 1'b0;
		skip     = 1'b0;
		bpr2     = bpr;
		accept_ok = can_push;
		if (byp_en_q) begin
			byp      = bpr && pv;
			pvi      = !empty || pv;
			skip     = empty && byp;
			bpr2     = reg_pop_q ? (bpr && pvi) : bpr;
			did_pop  = (!empty || byp) && bpr2 && !skip;
			did_push = (can_push || byp) && pv && !skip;
		end else begin
			pvi      = !empty;
			did_pop  = pvi && bpr;
			did_push = can_push && pv;
		end
		if (reg_push_q) begin
			accept_ok = not_full;
			did_push  = did_push && not_full;
		end

		pop_data_int = (byp_en_q && empty) ? pd : head;
		out_avail    = reg_pop_q ? ovr_q : pvi;
		pop_data_out = reg_pop_q ? odr_q : pop_data_int;

		// occupancy follows the port handshakes and wraps at pointer width
		pushed = accept_ok && pv;
		popped = pr && out_avail;
		occ_n  = occ_q;
		if (pushed && !popped) begin
			occ_n = occ_q + 1'b1;
		end else if (!pushed && popped) begin
			occ_n = occ_q - 1'b1;
		end

		wp_n = (acc && did_push) ? advance(wp_q) : wp_q;
		rp_n = (acc && did_pop) ? advance(rp_q) : rp_q;

		sctl.we  = acc && did_push;
		sctl.fwd = acc && did_push && (wp_q == rp_n);
	end

	sfbr_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sctl),
		.waddr   (wp_q),
		.wdata   (pd),
		.raddr_n (rp_n),
		.head    (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			occ_q     <= '0;
			ovr_q     <= 1'b0;
			odr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				wp_q      <= wp_n;
				rp_q      <= rp_n;
				occ_q     <= occ_n;
				m_valid_q <= 1'b1;
				if (load_en) begin
					ovr_q <= pvi;
					odr_q <= pop_data_int;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_data_q <= TW'({pop_data_out, out_avail, accept_ok});
		end
	end

	`SFBR_NEVER(a_no_overwrite, clk, arst_n, acc && m_valid_q && !m_tready, "response overwritten while stalled")
	`SFBR_ASSERT(a_resp_follows, clk, arst_n, acc |=> m_valid_q, "accepted request gave no response")
	`SFBR_NEVER(a_ptr_range, clk, arst_n, (wp_q > PW'(SLOTS - 1)) || (rp_q > PW'(SLOTS - 1)), "pointer past last slot")
	`SFBR_ASSERT(a_hold_idle, clk, arst_n, !acc |=> ($stable(wp_q) && $stable(rp_q) && $stable(occ_q)), "FIFO state moved without a request")

endmodule

`default_nettype wire

[tb/sv/sync_fifo_bypass_regpop_top_tb.sv]
// Testbench for the cycle-item FIFO: random and directed cycles checked against a local predictor.
module sync_fifo_bypass_regpop_top_tb
	import sfbr_pkg::*;
;

	localparam int DW          = DATA_WIDTH_DEF;
	localparam int TW          = ((DW + 2 + 7) / 8) * 8;
	localparam int SLOT_COUNT  = DEPTH_DEF + 1;
	// fewest bits that hold DEPTH+1, the width the occupancy counter wraps at
	localparam int PTR_W       = $clog2(SLOT_COUNT + 1);
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int PHASE_ITEMS = 225;
	localparam int LONG_HOLD   = 90;
	// index past the register list: the block must ignore it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// one response word: what the FIFO shows at its ports during one cycle
	typedef struct packed {
		logic          accept_ok;
		logic          out_avail;
		logic [DW-1:0] pop_data;
	} fifo_outputs_t;

	// Tracks FIFO state per accepted request, queues the port values each
	// request must produce, and matches responses against them in order.
	class fifo_cycle_board;
		logic                byp_on, rpush_on, rpop_on;
		logic [PTR_W-1:0]    wr_idx, rd_idx, fill_count;
		logic [DW-1:0]       slots [SLOT_COUNT];
		logic                stage_valid;
		logic [DW-1:0]       stage_data;
		fifo_outputs_t       awaiting [$];
		int                  failures;

		function new();
			byp_on = 1'b0;
			rpush_on = 1'b0;
			rpop_on = 1'b0;
			wr_idx = '0;
			rd_idx = '0;
			fill_count = '0;
			foreach (slots[i])
				slots[i] = '0;
			stage_valid = 1'b0;
			stage_data = '0;
			failures = 0;
		endfunction

		function void set_mode(logic [1:0] idx, logic val);
			case (idx)
				CFG_BYPASS:   byp_on = val;
				CFG_REG_PUSH: rpush_on = val;
				CFG_REG_POP:  rpop_on = val;
				default: ;
			endcase
		endfunction

		function int pending_count();
			return awaiting.size();
		endfunction

		function logic [PTR_W-1:0] step_index(logic [PTR_W-1:0] p);
			return PTR_W'((int'(p) + 1) % SLOT_COUNT);
		endfunction

		// one FIFO clock cycle: queue its outputs, then apply the edge
		function void note_cycle(logic pv, logic [DW-1:0] pd, logic pr);
			logic not_full, empty, load_en, bpr, can_push;
			logic byp, pushable, popable, avail_int, skip;
			logic vis_push, bpr2, vis_pop, did_push, did_pop, pushed, popped;
			logic [DW-1:0] pop_data_int;
			int tail_idx;
			fifo_outputs_t res;

			not_full = fill_count != PTR_W'(DEPTH_DEF);
			empty = wr_idx == rd_idx;
			load_en = 1'b0;
			bpr = pr;
			// output stage takes a word when the consumer pops or when it is empty
			if (rpop_on) begin
				load_en = pr || !stage_valid;
				bpr = load_en;
			end
			can_push = not_full || bpr;
			res.accept_ok = can_push;
			if (byp_on) begin
				byp = bpr && pv;
				pushable = can_push || byp;
				popable = !empty || byp;
				avail_int = !empty || pv;
				// push and pop on an empty buffer pass straight through
				skip = empty && byp;
				vis_push = pushable && pv;
				bpr2 = rpop_on ? (bpr && avail_int) : bpr;
				vis_pop = popable && bpr2;
				did_pop = vis_pop && !skip;
				did_push = vis_push && !skip;
			end else begin
				avail_int = !empty;
				did_pop = avail_int && bpr;
				did_push = can_push && pv;
			end
			if (rpush_on) begin
				res.accept_ok = not_full;
				did_push = did_push && not_full;
			end

			tail_idx = (int'(rd_idx) >= SLOT_COUNT) ? SLOT_COUNT - 1 : int'(rd_idx);
			pop_data_int = (byp_on && empty) ? pd : slots[tail_idx];
			if (rpop_on) begin
				res.out_avail = stage_valid;
				res.pop_data = stage_data;
			end else begin
				res.out_avail = avail_int;
				res.pop_data = pop_data_int;
			end
			awaiting.insert(awaiting.size(), res);

			// occupancy follows the port handshakes and wraps at the pointer width
			pushed = res.accept_ok && pv;
			popped = pr && res.out_avail;
			if (pushed && !popped)
				fill_count = fill_count + 1'b1;
			else if (!pushed && popped)
				fill_count = fill_count - 1'b1;

			if (did_push && int'(wr_idx) < SLOT_COUNT)
				slots[wr_idx] = pd;
			if (did_push)
				wr_idx = step_index(wr_idx);
			if (did_pop)
				rd_idx = step_index(rd_idx);
			// stage is frozen while registered pop is off
			if (rpop_on && load_en) begin
				stage_valid = avail_int;
				stage_data = pop_data_int;
			end
		endfunction

		function void check_cycle(logic [TW-1:0] word);
			fifo_outputs_t want, got;

			got.accept_ok = word[0];
			got.out_avail = word[1];
			got.pop_data = word[DW+1:2];
			if (awaiting.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected response: push accept %0b pop valid %0b pop_data %h",
						got.accept_ok, got.out_avail, got.pop_data);
				return;
			end
			want = awaiting.pop_front();
			if (got.accept_ok !== want.accept_ok || got.out_avail !== want.out_avail ||
					got.pop_data !== want.pop_data) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("mismatch: push accept %0b/%0b pop valid %0b/%0b pop_data %h/%h (exp/got)",
						want.accept_ok, got.accept_ok, want.out_avail, got.out_avail,
						want.pop_data, got.pop_data);
			end
		endfunction
	endclass

	// clock, reset and all block inputs known from time zero
	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [TW-1:0] s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [TW-1:0] m_tdata;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = '0;
	logic          cfg_data = 1'b0;

	// idling knobs, in percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// set by the stimulus to ask the receiver for one long hold-off
	bit hold_trigger = 1'b0;
	int cycle_count = 0;

	fifo_cycle_board board = new();

	sync_fifo_bypass_regpop_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // push offer, push word, pop_ready, zero pad
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // push accept, pop valid, pop_data, zero pad
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Handshakes are sampled at the edge, before any NBA of this step lands.
	// The request is noted first so a response in the same edge finds its slot.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_cycle(s_tdata[0], s_tdata[DW:1], s_tdata[DW+1]);
			if (m_tvalid && m_tready)
				board.check_cycle(m_tdata);
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so the
	// response side backs up and the block has to drop s_tready.
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_trigger) begin
			hold_trigger = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one request = one FIFO cycle; sender gaps come before the offer
	task automatic send_cycle(input logic pv, input logic [DW-1:0] pd, input logic pr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TW'({pr, pd, pv});
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// stop offering and wait for every outstanding response, then let the
	// response side settle before returning
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending_count() != 0);
		repeat (4) @(posedge clk);
	endtask

	// mode writes, only while idle; the unused index goes along and is ignored
	task automatic program_modes(input logic byp, input logic rpush, input logic rpop);
		logic [1:0] idx [4];
		logic       val [4];

		idx = '{CFG_BYPASS, CFG_REG_PUSH, CFG_REG_POP, CFG_UNUSED};
		val = '{byp, rpush, rpop, 1'($urandom_range(1))};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			board.set_mode(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_rate();
		case ($urandom_range(2))
			0:       return 10;
			1:       return 50;
			default: return 90;
		endcase
	endfunction

	initial begin
		// mode sets per phase, extremes included: {bypass, reg push, reg pop}
		logic [2:0] mode_seq [8];
		logic [DW-1:0] pattern;
		int push_pct, pop_pct, run_left;

		mode_seq = '{3'b111, 3'b100, 3'b001, 3'b110, 3'b000, 3'b011, 3'b010, 3'b101};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset modes: fill past full with data extremes, push and
		// pop while full, drain to empty, then push and pop on an empty FIFO.
		for (int i = 0; i < 22; i++) begin
			case (i % 4)
				0:       pattern = '0;
				1:       pattern = '1;
				2:       pattern = {(DW/2){2'b01}};
				default: pattern = {(DW/2){2'b10}};
			endcase
			if (i < 10)
				send_cycle(1'b1, pattern, 1'b0);
			else if (i == 10)
				send_cycle(1'b1, pattern, 1'b1);
			else if (i < 20)
				send_cycle(1'b0, pattern, 1'b1);
			else if (i == 20)
				send_cycle(1'b1, $urandom, 1'b1);
			else
				send_cycle(1'b0, $urandom, 1'b0);
		end
		settle();

		// Random phases; the FIFO is not drained between them, so each mode
		// change takes over whatever the buffer and output stage hold.
		for (int ph = 0; ph < 8; ph++) begin
			program_modes(mode_seq[ph][2], mode_seq[ph][1], mode_seq[ph][0]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			run_left = 0;
			push_pct = 50;
			pop_pct = 50;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// fill and drain tilts so full and empty are both reached often
				if (run_left == 0) begin
					push_pct = pick_rate();
					pop_pct = pick_rate();
					run_left = $urandom_range(40, 8);
				end
				run_left--;
				send_cycle($urandom_range(99) < push_pct, $urandom, $urandom_range(99) < pop_pct);
				if (n == 60 && (ph == 0 || ph == 5))
					hold_trigger = 1'b1;
				// sender holds back until all responses are in
				if (n == 120 && ph == 3)
					settle();
			end
			settle();
		end

		if (board.failures == 0 && board.pending_count() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
